### sv/stq_pkg.sv
// Shared types and constants for the sparse table range query block.
`timescale 1ns / 1ps

package stq_pkg;

   localparam int FIELD_WIDTH  = 32;  // width of the value and result fields
   localparam int INDEX_WIDTH  = 11;  // width of the left and right fields
   localparam int OP_WIDTH     = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // combining operations
   localparam logic [OP_WIDTH-1:0] OP_MIN = 2'd0;
   localparam logic [OP_WIDTH-1:0] OP_MAX = 2'd1;
   localparam logic [OP_WIDTH-1:0] OP_AND = 2'd2;
   localparam logic [OP_WIDTH-1:0] OP_OR  = 2'd3;

   // response status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_EMPTY  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_BEYOND = 2'd2;

   // register index of op_mode
   localparam logic REG_OP_MODE = 1'b0;

   typedef struct packed {
      logic capture;     // latch the request fields
      logic load;        // store one element
      logic build_step;  // read a pair of the lower level for one entry
      logic gap;         // close a level, move to the next
      logic q_issue;     // evaluate a query and read the two entries
      logic rsp_load;    // fill the output register
   } stq_cmd_type;

   typedef struct packed {
      logic last_q;      // captured element carries the last mark
      logic sweep_end;   // current entry is the final one of the level
      logic level_end;   // current level is the top one
   } stq_sts_type;

endpackage

### sv/stq_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps

module stq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### sv/stq_ctrl.sv
// Controller state machine: load, table build sweep, query sequencing, response valid.
`timescale 1ns / 1ps

module stq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic                 req_kind,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  stq_pkg::stq_sts_type sts,
   output stq_pkg::stq_cmd_type cmd
);

   import stq_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LOAD  = 3'd1;
   localparam logic [2:0] S_BUILD = 3'd2;
   localparam logic [2:0] S_GAP   = 3'd3;
   localparam logic [2:0] S_QISS  = 3'd4;
   localparam logic [2:0] S_QDATA = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = (req_kind == KIND_QUERY) ? S_QISS : S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = sts.last_q ? S_BUILD : S_IDLE;
         end
         S_BUILD: begin
            cmd.build_step = 1'b1;
            if (sts.sweep_end) begin
               state_in = S_GAP;
            end
         end
         S_GAP: begin
            // lets the level's final write land before the next level reads it
            cmd.gap  = 1'b1;
            state_in = sts.level_end ? S_IDLE : S_BUILD;
         end
         S_QISS: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.q_issue = 1'b1;
               state_in    = S_QDATA;
            end
         end
         S_QDATA: begin
            cmd.rsp_load = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_rsp_reg_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> !rsp_valid_ff)
      else $error("output register overwritten while holding a response");

   a_gap_after_build: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GAP) |-> ($past(state_ff) == S_BUILD))
      else $error("level gap entered outside a build sweep");

   a_build_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD && sts.last_q) |=> (state_ff == S_BUILD))
      else $error("last element did not start the table build");

endmodule

### sv/stq_dp.sv
// Datapath: element counters, build sweep counters, level memory, query evaluation, output register.
`timescale 1ns / 1ps

module stq_dp #(
   parameter int MAX_ENTRIES = 1024,
   parameter int LEVELS      = 11,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  stq_pkg::stq_cmd_type                 cmd,
   output stq_pkg::stq_sts_type                 sts,
   input  logic [stq_pkg::OP_WIDTH-1:0]         op_mode,
   input  logic [stq_pkg::FIELD_WIDTH-1:0]      req_value,
   input  logic                                 req_last,
   input  logic [stq_pkg::INDEX_WIDTH-1:0]      req_left,
   input  logic [stq_pkg::INDEX_WIDTH-1:0]      req_right,
   output logic [stq_pkg::FIELD_WIDTH-1:0]      rsp_result,
   output logic [stq_pkg::STATUS_WIDTH-1:0]     rsp_status
);

   import stq_pkg::*;

   localparam int IW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW    = $clog2(MAX_ENTRIES + 1);
   localparam int LW    = $clog2(LEVELS);
   localparam int AW    = LW + IW;
   localparam int DEPTH = LEVELS * (2 ** IW);
   localparam int WW    = LEVELS - 1;                       // partner distance width
   localparam int SW    = ((CW > WW) ? CW : WW) + 1;        // partner index sum width
   localparam int QW    = (CW > INDEX_WIDTH) ? CW : INDEX_WIDTH;
   localparam int KW    = $clog2(INDEX_WIDTH);

   function automatic logic [VALUE_WIDTH-1:0] combine(input logic [OP_WIDTH-1:0] op,
                                                      input logic [VALUE_WIDTH-1:0] a,
                                                      input logic [VALUE_WIDTH-1:0] b);
      logic [VALUE_WIDTH-1:0] r;
      case (op)
         OP_MIN:  r = (a < b) ? a : b;
         OP_MAX:  r = (a > b) ? a : b;
         OP_AND:  r = a & b;
         default: r = a | b;
      endcase
      return r;
   endfunction

   // request capture
   logic [FIELD_WIDTH-1:0] value_ff;
   logic                   last_ff;
   logic [INDEX_WIDTH-1:0] left_ff, right_ff;

   // array state
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] size_ff, size_in;
   logic [CW-1:0] cnt_base;

   // build sweep
   logic [IW-1:0] j_ff, j_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [WW-1:0] w_ff, w_in;
   logic          bwr_pend_ff;
   logic [AW-1:0] bwr_addr_ff;
   logic          pair_ff;
   logic [SW-1:0] partner;

   // query
   logic [STATUS_WIDTH-1:0] qstat_ff, qstat;
   logic [INDEX_WIDTH-1:0]  diff, pow, bidx;
   logic [KW-1:0]           kraw;
   logic [LW-1:0]           ksat;

   // memory ports
   logic                   wr_en, load_wr;
   logic [AW-1:0]          wr_addr, rd_addr_a, rd_addr_b;
   logic [VALUE_WIDTH-1:0] wr_data, rd_data_a, rd_data_b, ident;

   // output register
   logic [FIELD_WIDTH-1:0]  result_ff;
   logic [STATUS_WIDTH-1:0] status_ff;

   assign ident = (op_mode == OP_MIN || op_mode == OP_AND) ? '1 : '0;

   // load and build counters
   always_comb begin
      cnt_base = (size_ff != '0) ? '0 : count_ff;
      count_in = count_ff;
      size_in  = size_ff;
      j_in     = j_ff;
      lvl_in   = lvl_ff;
      w_in     = w_ff;
      load_wr  = 1'b0;
      if (cmd.load) begin
         size_in = '0;
         if (cnt_base < CW'(MAX_ENTRIES)) begin
            load_wr  = 1'b1;
            count_in = cnt_base + CW'(1);
         end else begin
            count_in = cnt_base;
         end
         j_in   = '0;
         lvl_in = LW'(1);
         w_in   = WW'(1);
      end
      if (cmd.build_step) begin
         j_in = j_ff + IW'(1);
      end
      if (cmd.gap) begin
         j_in   = '0;
         lvl_in = lvl_ff + LW'(1);
         w_in   = w_ff << 1;
         if (sts.level_end) begin
            size_in = count_ff;
         end
      end
   end

   assign partner       = SW'(j_ff) + SW'(w_ff);
   assign sts.last_q    = last_ff;
   assign sts.sweep_end = (CW'(j_ff) + CW'(1)) == count_ff;
   assign sts.level_end = lvl_ff == LW'(LEVELS - 1);

   // query evaluation
   always_comb begin
      diff = right_ff - left_ff;
      kraw = '0;
      for (int i = 1; i < INDEX_WIDTH; i++) begin
         if (diff[i]) begin
            kraw = KW'(i);
         end
      end
      if (32'(kraw) > LEVELS - 1) begin
         ksat = LW'(LEVELS - 1);
      end else begin
         ksat = LW'(kraw);
      end
      pow  = INDEX_WIDTH'(1) << ksat;
      bidx = right_ff - pow;
      if (bidx < left_ff) begin
         bidx = left_ff;
      end
      if (right_ff <= left_ff) begin
         qstat = STATUS_EMPTY;
      end else if (QW'(right_ff) > QW'(size_ff)) begin
         qstat = STATUS_BEYOND;
      end else begin
         qstat = STATUS_OK;
      end
   end

   // memory address and data selection
   always_comb begin
      if (cmd.q_issue) begin
         rd_addr_a = {ksat, IW'(left_ff)};
         rd_addr_b = {ksat, IW'(bidx)};
      end else begin
         rd_addr_a = {LW'(lvl_ff - LW'(1)), j_ff};
         rd_addr_b = {LW'(lvl_ff - LW'(1)), IW'(partner)};
      end
      wr_en = load_wr | bwr_pend_ff;
      if (load_wr) begin
         wr_addr = {LW'(0), IW'(cnt_base)};
         wr_data = VALUE_WIDTH'(value_ff);
      end else begin
         wr_addr = bwr_addr_ff;
         wr_data = pair_ff ? combine(op_mode, rd_data_a, rd_data_b) : rd_data_a;
      end
   end

   stq_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) u_level_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         size_ff     <= '0;
         bwr_pend_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         size_ff     <= size_in;
         bwr_pend_ff <= cmd.build_step;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         value_ff <= req_value;
         last_ff  <= req_last;
         left_ff  <= req_left;
         right_ff <= req_right;
      end
      j_ff   <= j_in;
      lvl_ff <= lvl_in;
      w_ff   <= w_in;
      if (cmd.build_step) begin
         bwr_addr_ff <= {lvl_ff, j_ff};
         pair_ff     <= partner < SW'(count_ff);
      end
      if (cmd.q_issue) begin
         qstat_ff <= qstat;
      end
      if (cmd.rsp_load) begin
         status_ff <= qstat_ff;
         result_ff <= (qstat_ff == STATUS_OK) ?
                      FIELD_WIDTH'(combine(op_mode, rd_data_a, rd_data_b)) :
                      FIELD_WIDTH'(ident);
      end
   end

   assign rsp_result = result_ff;
   assign rsp_status = status_ff;

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES))
      else $error("element count beyond capacity");

   a_size_matches: assert property (@(posedge clock) disable iff (reset)
      (size_ff != '0) |-> (size_ff == count_ff))
      else $error("built table size differs from element count");

   a_no_write_on_query: assert property (@(posedge clock) disable iff (reset)
      cmd.q_issue |-> !wr_en)
      else $error("memory write during query read");

endmodule

### sv/sparse_table_range_query.sv
// Top level of the sparse table range query block: stream ports, register port, controller and datapath.
`timescale 1ns / 1ps

// Elements are loaded one per request (tuser 0) and the one carrying tlast
// triggers a table build; a query (tuser 1) returns the min, max, AND or OR
// of the elements in [left, right), chosen by op_mode. The build fills levels
// 1 to LEVELS - 1, one entry per cycle through the level memory's two read
// ports, with a gap state between levels so the last write of a level settles
// before it is read. A query is evaluated and both entries read, then they are
// combined into the output register, which raises the response. A new request
// is taken only in idle, once the previous one is through; a response still
// waiting in the output register does not block acceptance, though a query
// then waits to issue until that response is taken. The level memory holds
// LEVELS x 2^ceil(log2(MAX_ENTRIES)) words and needs no clearing after reset.

module sparse_table_range_query #(
   parameter int MAX_ENTRIES = 1024,
   parameter int LEVELS      = 11,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [55:0]                           req_tdata,  // value[31:0], left[42:32], right[53:43], zero pad
   input  logic                                  req_tuser,  // kind
   input  logic                                  req_tlast,
   // response stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [stq_pkg::FIELD_WIDTH-1:0]       rsp_tdata,  // result[31:0]
   output logic [stq_pkg::STATUS_WIDTH-1:0]      rsp_tuser,  // status[1:0]
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [stq_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  logic [stq_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic [stq_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                  csr_pready
);

   import stq_pkg::*;

   logic [OP_WIDTH-1:0] op_mode_ff, op_mode_in;
   logic                csr_wr;
   stq_cmd_type         cmd;
   stq_sts_type         sts;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      op_mode_in = op_mode_ff;
      if (csr_wr && csr_paddr[2] == REG_OP_MODE) begin
         op_mode_in = csr_pwdata[OP_WIDTH-1:0];
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_OP_MODE: csr_prdata = CSR_DATA_WIDTH'(op_mode_ff);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_mode_ff <= OP_MIN;
      end else begin
         op_mode_ff <= op_mode_in;
      end
   end

   stq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   stq_dp #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .LEVELS      (LEVELS),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .op_mode    (op_mode_ff),
      .req_value  (req_tdata[31:0]),
      .req_last   (req_tlast),
      .req_left   (req_tdata[42:32]),
      .req_right  (req_tdata[53:43]),
      .rsp_result (rsp_tdata),
      .rsp_status (rsp_tuser)
   );

endmodule
